// File: hdl/fault_latch_dwell_retry_macros.svh
// Assertion macros used by the checker file.
`ifndef FAULT_LATCH_DWELL_RETRY_MACROS_SVH
`define FAULT_LATCH_DWELL_RETRY_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define FLDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define FLDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/fldr_pkg.sv
`default_nettype none
package fldr_pkg;

   localparam int unsigned CodeWidth = 8;
   localparam int unsigned TickWidth = 16;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 16;
   localparam logic [TickWidth-1:0] TickMax = {TickWidth{1'b1}};

   typedef enum logic [2:0] {
      OP_LATCH       = 3'd0,
      OP_TAKE        = 3'd1,
      OP_ENTER_FAULT = 3'd2,
      OP_TICK        = 3'd3,
      OP_TRY_CLEAR   = 3'd4,
      OP_RESET_COUNT = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      COND_UNKNOWN  = 2'd0,
      COND_CLEAR    = 2'd1,
      COND_ASSERTED = 2'd2
   } cond_type;

   typedef enum logic [1:0] {
      REFUSE_NONE     = 2'd0,
      REFUSE_ASSERTED = 2'd1,
      REFUSE_DWELL    = 2'd2,
      REFUSE_LIMIT    = 2'd3
   } refusal_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_POLL_INTERVAL = 2'd0,
      CSR_DWELL_TICKS   = 2'd1,
      CSR_MAX_CLEARS    = 2'd2
   } csr_index_type;

   localparam logic [TickWidth-1:0] PollIntervalReset = 16'd10;
   localparam logic [TickWidth-1:0] DwellTicksReset = 16'd100;
   localparam logic [CountWidth-1:0] MaxClearsReset = 8'd3;

   typedef struct packed {
      logic                      write;
      logic [CsrIndexWidth-1:0]  index;
      logic [CsrDataWidth-1:0]   data;
   } csr_write_type;

   typedef struct packed {
      logic                  code_valid;
      logic [CodeWidth-1:0]  code_out;
      logic [1:0]            refusal;
      logic                  cleared;
      logic                  latched_now;
      logic                  recorded_now;
      logic                  pending_now;
      logic [1:0]            condition_now;
   } result_type;

endpackage
`default_nettype wire

// File: hdl/fldr_core.sv
`default_nettype none
module fldr_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire fldr_pkg::csr_write_type         csr,
   input  wire logic                            accept,
   input  wire logic [2:0]                      op,
   input  wire logic [fldr_pkg::CodeWidth-1:0]  fault_code,
   input  wire logic [1:0]                      condition_sample,
   output fldr_pkg::result_type                 result
);

   logic [fldr_pkg::TickWidth-1:0]  poll_interval_ff;
   logic [fldr_pkg::TickWidth-1:0]  dwell_ticks_ff;
   logic [fldr_pkg::CountWidth-1:0] max_clears_ff;

   logic [fldr_pkg::CodeWidth-1:0]  held_code_ff, held_code_in;
   logic                            pending_ff, pending_in;
   logic                            latched_ff, latched_in;
   logic                            recorded_ff, recorded_in;
   logic                            polling_ff, polling_in;
   logic [fldr_pkg::TickWidth-1:0]  poll_count_ff, poll_count_in;
   logic [1:0]                      last_cond_ff, last_cond_in;
   logic                            clear_seen_ff, clear_seen_in;
   logic [fldr_pkg::TickWidth-1:0]  clear_age_ff, clear_age_in;
   logic [fldr_pkg::CountWidth-1:0] clear_count_ff, clear_count_in;

   logic [fldr_pkg::TickWidth-1:0]  poll_next;
   logic [1:0]                      sample;
   logic [1:0]                      refusal;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff <= fldr_pkg::PollIntervalReset;
         dwell_ticks_ff   <= fldr_pkg::DwellTicksReset;
         max_clears_ff    <= fldr_pkg::MaxClearsReset;
      end else if (csr.write) begin
         case (csr.index)
            fldr_pkg::CSR_POLL_INTERVAL: poll_interval_ff <= csr.data;
            fldr_pkg::CSR_DWELL_TICKS:   dwell_ticks_ff <= csr.data;
            fldr_pkg::CSR_MAX_CLEARS:    max_clears_ff <= csr.data[fldr_pkg::CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // Clear-gate verdict on the state before this transaction.
   always_comb begin
      if (last_cond_ff == fldr_pkg::COND_ASSERTED) begin
         refusal = fldr_pkg::REFUSE_ASSERTED;
      end else if (last_cond_ff == fldr_pkg::COND_CLEAR &&
                   (!clear_seen_ff || clear_age_ff < dwell_ticks_ff)) begin
         refusal = fldr_pkg::REFUSE_DWELL;
      end else if (clear_count_ff >= max_clears_ff) begin
         refusal = fldr_pkg::REFUSE_LIMIT;
      end else begin
         refusal = fldr_pkg::REFUSE_NONE;
      end
   end

   always_comb begin
      held_code_in   = held_code_ff;
      pending_in     = pending_ff;
      latched_in     = latched_ff;
      recorded_in    = recorded_ff;
      polling_in     = polling_ff;
      poll_count_in  = poll_count_ff;
      last_cond_in   = last_cond_ff;
      clear_seen_in  = clear_seen_ff;
      clear_age_in   = clear_age_ff;
      clear_count_in = clear_count_ff;
      result         = '0;

      // A sample code of three reads as unknown.
      sample = (condition_sample == 2'd3) ? fldr_pkg::COND_UNKNOWN : condition_sample;
      poll_next = (poll_count_ff != fldr_pkg::TickMax) ?
                  poll_count_ff + fldr_pkg::TickWidth'(1) : poll_count_ff;

      case (fldr_pkg::op_type'(op))
         fldr_pkg::OP_LATCH: begin
            held_code_in = fault_code;
            pending_in   = 1'b1;
            latched_in   = 1'b1;
         end
         fldr_pkg::OP_TAKE: begin
            if (pending_ff) begin
               result.code_valid = 1'b1;
               result.code_out   = held_code_ff;
               pending_in        = 1'b0;
            end
         end
         fldr_pkg::OP_ENTER_FAULT: begin
            latched_in    = 1'b1;
            recorded_in   = 1'b1;
            polling_in    = 1'b1;
            poll_count_in = '0;
         end
         fldr_pkg::OP_TICK: begin
            if (clear_seen_ff && clear_age_ff != fldr_pkg::TickMax) begin
               clear_age_in = clear_age_ff + fldr_pkg::TickWidth'(1);
            end
            if (polling_ff) begin
               poll_count_in = poll_next;
               if (poll_next >= poll_interval_ff) begin
                  poll_count_in = '0;
                  last_cond_in  = sample;
                  if (sample == fldr_pkg::COND_ASSERTED) begin
                     clear_seen_in = 1'b0;
                  end else if (sample == fldr_pkg::COND_CLEAR &&
                               last_cond_ff != fldr_pkg::COND_CLEAR) begin
                     // Start a new clear stretch.
                     clear_seen_in = 1'b1;
                     clear_age_in  = '0;
                  end
               end
            end
         end
         fldr_pkg::OP_TRY_CLEAR: begin
            result.refusal = refusal;
            if (refusal == fldr_pkg::REFUSE_NONE) begin
               result.cleared = 1'b1;
               clear_count_in = clear_count_ff + fldr_pkg::CountWidth'(1);
               latched_in     = 1'b0;
               recorded_in    = 1'b0;
               polling_in     = 1'b0;
               poll_count_in  = '0;
               clear_seen_in  = 1'b0;
               clear_age_in   = '0;
               last_cond_in   = fldr_pkg::COND_UNKNOWN;
            end
         end
         fldr_pkg::OP_RESET_COUNT: begin
            clear_count_in = '0;
         end
         default: ;
      endcase

      result.latched_now   = latched_in;
      result.recorded_now  = recorded_in;
      result.pending_now   = pending_in;
      result.condition_now = last_cond_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_code_ff   <= '0;
         pending_ff     <= 1'b0;
         latched_ff     <= 1'b0;
         recorded_ff    <= 1'b0;
         polling_ff     <= 1'b0;
         poll_count_ff  <= '0;
         last_cond_ff   <= fldr_pkg::COND_UNKNOWN;
         clear_seen_ff  <= 1'b0;
         clear_age_ff   <= '0;
         clear_count_ff <= '0;
      end else if (accept) begin
         held_code_ff   <= held_code_in;
         pending_ff     <= pending_in;
         latched_ff     <= latched_in;
         recorded_ff    <= recorded_in;
         polling_ff     <= polling_in;
         poll_count_ff  <= poll_count_in;
         last_cond_ff   <= last_cond_in;
         clear_seen_ff  <= clear_seen_in;
         clear_age_ff   <= clear_age_in;
         clear_count_ff <= clear_count_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/fldr_out_buf.sv
`default_nettype none
module fldr_out_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire fldr_pkg::result_type  in_data,
   output logic                       in_stall,
   output logic                       out_valid,
   output fldr_pkg::result_type       out_data,
   input  wire logic                  out_stall
);

   logic                  main_valid_ff;
   fldr_pkg::result_type  main_ff;
   logic                  skid_valid_ff;
   fldr_pkg::result_type  skid_ff;
   logic                  main_free;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign main_free = !main_valid_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         // Drain the skid entry first; input is held off while it is full.
         main_valid_ff <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end
      if (!main_free && !skid_valid_ff) begin
         skid_ff <= in_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/fault_latch_dwell_retry.sv
// Fault latch with a dwell-gated, budgeted clear.
//
// Request channel (req_valid/req_stall) carries one transaction per event:
// req_op selects latch, take, enter fault, tick, try clear or reset count;
// req_fault_code is used by latch, req_condition_sample by tick.
// Every request transaction yields exactly one response transaction on
// rsp_valid/rsp_stall with the take, clear and flag results.
// Each response is registered in the output buffer (main register, or skid
// register while rsp_stall holds the main entry); the state update finishes
// in the accepting cycle, so one request per cycle is sustained while rsp_stall is low.
// A two-entry output buffer sits on the response side: with rsp_stall high
// one more request is still taken, then req_stall rises until the buffer
// drains. req_stall is a register output.
// The csr_ port writes poll_interval (0), dwell_ticks (1) and max_clears
// (2); csr_ready is always high. Write only while no response is pending.
// Synchronous reset clears all fault state, empties the buffer and loads
// register defaults 10, 100 and 3.
`default_nettype none
module fault_latch_dwell_retry (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_op,
   input  wire logic [fldr_pkg::CodeWidth-1:0]      req_fault_code,
   input  wire logic [1:0]                          req_condition_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_code_valid,
   output logic [fldr_pkg::CodeWidth-1:0]           rsp_code_out,
   output logic [1:0]                               rsp_refusal,
   output logic                                     rsp_cleared,
   output logic                                     rsp_latched_now,
   output logic                                     rsp_recorded_now,
   output logic                                     rsp_pending_now,
   output logic [1:0]                               rsp_condition_now,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fldr_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [fldr_pkg::CsrDataWidth-1:0]   csr_data
);

   fldr_pkg::csr_write_type  csr;
   fldr_pkg::result_type     core_result;
   fldr_pkg::result_type     rsp_data;
   logic                     req_accept;

   assign csr_ready  = 1'b1;
   assign csr.write  = csr_valid && csr_ready;
   assign csr.index  = csr_index;
   assign csr.data   = csr_data;
   assign req_accept = req_valid && !req_stall;

   fldr_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr),
      .accept           (req_accept),
      .op               (req_op),
      .fault_code       (req_fault_code),
      .condition_sample (req_condition_sample),
      .result           (core_result)
   );

   fldr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (core_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_code_valid    = rsp_data.code_valid;
   assign rsp_code_out      = rsp_data.code_out;
   assign rsp_refusal       = rsp_data.refusal;
   assign rsp_cleared       = rsp_data.cleared;
   assign rsp_latched_now   = rsp_data.latched_now;
   assign rsp_recorded_now  = rsp_data.recorded_now;
   assign rsp_pending_now   = rsp_data.pending_now;
   assign rsp_condition_now = rsp_data.condition_now;

endmodule
`default_nettype wire

// File: hdl/fldr_checker.sv
`default_nettype none
`include "fault_latch_dwell_retry_macros.svh"
module fldr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_code_valid,
   input wire logic [1:0]  rsp_refusal,
   input wire logic        rsp_cleared,
   input wire logic        rsp_latched_now,
   input wire logic        rsp_recorded_now,
   input wire logic        rsp_pending_now,
   input wire logic [1:0]  rsp_condition_now
);

   `FLDR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   `FLDR_ASSERT_NOW(a_clear_resets, clock, reset, rsp_valid && rsp_cleared, rsp_refusal == fldr_pkg::REFUSE_NONE && !rsp_latched_now && !rsp_recorded_now && rsp_condition_now == fldr_pkg::COND_UNKNOWN, "clear left fault state set")
   `FLDR_ASSERT_NOW(a_take_pops, clock, reset, rsp_valid && rsp_code_valid, !rsp_pending_now && rsp_refusal == fldr_pkg::REFUSE_NONE && !rsp_cleared, "take kept pending code")
   `FLDR_ASSERT_NOW(a_asserted_refusal, clock, reset, rsp_valid && rsp_refusal == fldr_pkg::REFUSE_ASSERTED, rsp_condition_now == fldr_pkg::COND_ASSERTED, "asserted refusal without asserted condition")
   `FLDR_ASSERT_NOW(a_dwell_refusal, clock, reset, rsp_valid && rsp_refusal == fldr_pkg::REFUSE_DWELL, rsp_condition_now == fldr_pkg::COND_CLEAR, "dwell refusal without clear condition")

endmodule

bind fault_latch_dwell_retry fldr_checker u_fldr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_code_valid    (rsp_code_valid),
   .rsp_refusal       (rsp_refusal),
   .rsp_cleared       (rsp_cleared),
   .rsp_latched_now   (rsp_latched_now),
   .rsp_recorded_now  (rsp_recorded_now),
   .rsp_pending_now   (rsp_pending_now),
   .rsp_condition_now (rsp_condition_now)
);
`default_nettype wire
